// ----- design/mae_pkg.sv -----
// Shared types and constants for the modular arithmetic engine.
package mae_pkg;

  localparam int WORD_W      = 64;
  localparam int WORDS_DEF   = 4;
  localparam int FUNC_W      = 3;
  localparam int IDX_W       = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [FUNC_W-1:0] {
    FN_LD_M = 3'd0,
    FN_LD_A = 3'd1,
    FN_LD_B = 3'd2,
    FN_ADD  = 3'd3,
    FN_SUB  = 3'd4,
    FN_MUL  = 3'd5,
    FN_EXP  = 3'd6,
    FN_NONE = 3'd7
  } func_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR_R,
    OP_RED_STEP,
    OP_DBL,
    OP_ADDX,
    OP_ADD_AB,
    OP_SUB_AB,
    OP_LD_RA,
    OP_LD_RB,
    OP_SET_AB,
    OP_SET_SQ,
    OP_SET_MA,
    OP_RES_R,
    OP_RES_A,
    OP_RES_ONE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     inbit;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_LD_RA,
    ST_RED_B,
    ST_LD_RB,
    ST_DISPATCH,
    ST_FIN,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_MUL_END,
    ST_EXP_SCAN,
    ST_EXP_SQ_SET,
    ST_EXP_MA_SET,
    ST_EXP_NEXT,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MK_PLAIN,
    MK_SQ,
    MK_MA
  } mul_kind_t;

endpackage

// ----- design/mae_cell.sv -----
// One 64-bit slice of the operand, accumulator and modulus registers.
module mae_cell (
  input  logic                clk,
  input  logic                rst,
  input  mae_pkg::cell_ctrl_t ctrl,
  input  logic                is_lsb,
  input  logic                pick,
  input  logic                ld_m,
  input  logic                ld_a,
  input  logic                ld_b,
  input  logic [63:0]         ld_val,
  input  logic                shin,
  input  logic                cin,
  input  logic                c2in,
  output logic                shout,
  output logic                cout,
  output logic                c2out,
  output logic [63:0]         m_word,
  output logic [63:0]         a_word,
  output logic [63:0]         b_word,
  output logic [63:0]         mp_word,
  output logic [63:0]         res_word
);
  import mae_pkg::*;

  logic [WORD_W-1:0] m, a_st, b_st, ra, rb, mc, mp, r, res;
  logic [WORD_W-1:0] x, y, s, d, mop, rnew;

  always_comb begin
    unique case (ctrl.op)
      OP_RED_STEP, OP_DBL: begin
        x = {r[WORD_W-2:0], shin};
        y = '0;
      end
      OP_ADDX: begin
        x = r;
        y = mc;
      end
      OP_ADD_AB: begin
        x = ra;
        y = rb;
      end
      OP_SUB_AB: begin
        x = ra;
        y = ~rb;
      end
      default: begin
        x = r;
        y = '0;
      end
    endcase
  end

  // first stage: sum (or difference); second stage: minus m (or plus m on subtract)
  assign {cout, s}  = {1'b0, x} + {1'b0, y} + (WORD_W+1)'(cin);
  assign mop        = (ctrl.op == OP_SUB_AB) ? m : ~m;
  assign {c2out, d} = {1'b0, s} + {1'b0, mop} + (WORD_W+1)'(c2in);
  assign rnew       = pick ? d : s;
  assign shout      = r[WORD_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m    <= '0;
      a_st <= '0;
      b_st <= '0;
    end else begin
      if (ld_m) m <= ld_val;
      if (ld_a) a_st <= ld_val;
      if (ld_b) b_st <= ld_val;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_RED_STEP, OP_DBL, OP_ADDX, OP_ADD_AB, OP_SUB_AB: begin
        r <= rnew;
      end
      OP_CLR_R: begin
        r <= '0;
      end
      OP_LD_RA: begin
        ra <= r;
        r  <= '0;
      end
      OP_LD_RB: begin
        rb <= r;
        r  <= '0;
      end
      OP_SET_AB: begin
        mc <= ra;
        mp <= rb;
        r  <= '0;
      end
      OP_SET_SQ: begin
        mc <= res;
        mp <= res;
        r  <= '0;
      end
      OP_SET_MA: begin
        mc <= ra;
        mp <= res;
        r  <= '0;
      end
      OP_RES_R: begin
        res <= r;
      end
      OP_RES_A: begin
        res <= ra;
      end
      OP_RES_ONE: begin
        res <= is_lsb ? WORD_W'(1) : '0;
      end
      default: begin
      end
    endcase
  end

  assign m_word   = m;
  assign a_word   = a_st;
  assign b_word   = b_st;
  assign mp_word  = mp;
  assign res_word = res;

endmodule

// ----- design/mae_ctrl.sv -----
// Sequencer: operand reduction, modular add/subtract, shift-add modular multiply, square-and-multiply.
module mae_ctrl #(
  parameter int WORDS = mae_pkg::WORDS_DEF,
  parameter int N     = WORDS * mae_pkg::WORD_W,
  parameter int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_func,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [WIDX_W-1:0]      out_widx,
  output logic                   out_last,
  output logic                   out_err,
  input  logic [N-1:0]           a_vec,
  input  logic [N-1:0]           b_vec,
  input  logic [N-1:0]           mp_vec,
  input  logic                   m_small,
  output mae_pkg::cell_ctrl_t    ctrl
);
  import mae_pkg::*;

  localparam int CNT_W = $clog2(N);

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, ecnt;
  mul_kind_t         kind;
  logic [WIDX_W-1:0] widx;
  func_t             func_r;
  logic              err;
  logic              acc, is_op;

  assign in_ready  = (state == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign is_op     = (in_func == FN_ADD) || (in_func == FN_SUB) ||
                     (in_func == FN_MUL) || (in_func == FN_EXP);
  assign out_valid = (state == ST_OUT);
  assign out_widx  = widx;
  assign out_last  = (widx == WIDX_W'(WORDS - 1));
  assign out_err   = err;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (acc && is_op) state_next = m_small ? ST_OUT : ST_RED_A;
      ST_RED_A:    if (cnt == '0) state_next = ST_LD_RA;
      ST_LD_RA:    state_next = ST_RED_B;
      ST_RED_B:    if (cnt == '0) state_next = ST_LD_RB;
      ST_LD_RB:    state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        priority case (func_r)
          FN_ADD, FN_SUB: state_next = ST_FIN;
          FN_MUL:         state_next = ST_MUL_DBL;
          default:        state_next = ST_EXP_SCAN;
        endcase
      end
      ST_FIN:      state_next = ST_OUT;
      ST_MUL_DBL:  state_next = ST_MUL_ADD;
      ST_MUL_ADD:  state_next = (cnt == '0) ? ST_MUL_END : ST_MUL_DBL;
      ST_MUL_END: begin
        unique case (kind)
          MK_PLAIN: state_next = ST_OUT;
          MK_SQ:    state_next = b_vec[ecnt] ? ST_EXP_MA_SET : ST_EXP_NEXT;
          default:  state_next = ST_EXP_NEXT;
        endcase
      end
      ST_EXP_SCAN: begin
        if (ecnt == '0) state_next = ST_OUT;
        else if (b_vec[ecnt]) state_next = ST_EXP_SQ_SET;
      end
      ST_EXP_SQ_SET: state_next = ST_MUL_DBL;
      ST_EXP_MA_SET: state_next = ST_MUL_DBL;
      ST_EXP_NEXT:   state_next = (ecnt == '0) ? ST_OUT : ST_EXP_SQ_SET;
      ST_OUT:        if (out_ready && out_last) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.op    = OP_NOP;
    ctrl.inbit = 1'b0;
    unique case (state)
      ST_IDLE:  if (acc && is_op) ctrl.op = OP_CLR_R;
      ST_RED_A: begin
        ctrl.op    = OP_RED_STEP;
        ctrl.inbit = a_vec[cnt];
      end
      ST_LD_RA: ctrl.op = OP_LD_RA;
      ST_RED_B: begin
        ctrl.op    = OP_RED_STEP;
        ctrl.inbit = b_vec[cnt];
      end
      ST_LD_RB: ctrl.op = OP_LD_RB;
      ST_DISPATCH: begin
        priority case (func_r)
          FN_ADD:  ctrl.op = OP_ADD_AB;
          FN_SUB:  ctrl.op = OP_SUB_AB;
          FN_MUL:  ctrl.op = OP_SET_AB;
          default: ctrl.op = OP_NOP;
        endcase
      end
      ST_FIN:        ctrl.op = OP_RES_R;
      ST_MUL_DBL:    ctrl.op = OP_DBL;
      ST_MUL_ADD:    ctrl.op = mp_vec[cnt] ? OP_ADDX : OP_NOP;
      ST_MUL_END:    ctrl.op = OP_RES_R;
      ST_EXP_SCAN: begin
        // top set bit loads the base; no set bit at all gives one
        if (b_vec[ecnt]) ctrl.op = OP_RES_A;
        else if (ecnt == '0) ctrl.op = OP_RES_ONE;
      end
      ST_EXP_SQ_SET: ctrl.op = OP_SET_SQ;
      ST_EXP_MA_SET: ctrl.op = OP_SET_MA;
      default:       ctrl.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      ecnt   <= '0;
      kind   <= MK_PLAIN;
      widx   <= '0;
      func_r <= FN_NONE;
      err    <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (acc && is_op) begin
            cnt    <= CNT_W'(N - 1);
            ecnt   <= CNT_W'(N - 1);
            func_r <= func_t'(in_func);
            err    <= m_small;
            widx   <= '0;
          end
        end
        ST_RED_A, ST_RED_B, ST_MUL_ADD: if (cnt != '0) cnt <= cnt - 1'b1;
        ST_LD_RA: cnt <= CNT_W'(N - 1);
        ST_DISPATCH: begin
          cnt  <= CNT_W'(N - 1);
          kind <= MK_PLAIN;
        end
        ST_EXP_SCAN, ST_EXP_NEXT: if (ecnt != '0) ecnt <= ecnt - 1'b1;
        ST_EXP_SQ_SET: begin
          cnt  <= CNT_W'(N - 1);
          kind <= MK_SQ;
        end
        ST_EXP_MA_SET: begin
          cnt  <= CNT_W'(N - 1);
          kind <= MK_MA;
        end
        ST_OUT: if (out_ready) widx <= widx + 1'b1;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/modular_arithmetic_engine_top.sv -----
// Top level: stream ports, row of word cells with carry chains, sequencer.
//
//  channel   | dir | tdata (low bit up)                    | tuser          | tlast
//  s_axis    | in  | word_index[1:0], word_value[63:0], 0s | func[2:0]      | -
//  m_axis    | out | result_word[63:0], result_index, 0s   | modulus_error  | last_word
//
// N = 64*WORDS bits. An operation beat first reduces both operands mod m, then adds,
// subtracts, multiplies by shift-add, or exponentiates by square-and-multiply from the
// top set exponent bit down (a zero exponent gives one). Loads do not leave the idle
// state; results then take WORDS beats.
// Synchronous reset clears the modulus and operand words and the sequencer.
// s_axis_tready is low from an operation beat until its last result beat
// is taken; an output stall holds the sequencer in place.
module modular_arithmetic_engine_top #(
  parameter int WORDS = mae_pkg::WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mae_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // word_index[1:0], word_value[65:2]
  input  logic [mae_pkg::FUNC_W-1:0]      s_axis_tuser,  // func[2:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mae_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // result_word[63:0], result_index[65:64]
  output logic [0:0]                      m_axis_tuser,  // modulus_error
  output logic                            m_axis_tlast
);
  import mae_pkg::*;

  localparam int N      = WORDS * WORD_W;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  cell_ctrl_t        ctrl;
  logic [N-1:0]      m_vec, a_vec, b_vec, mp_vec;
  logic [WORD_W-1:0] res_w [WORDS];
  logic [WORDS:0]    sh, cc, c2;
  logic              pick, is_sub, is_shift, m_small, acc;
  logic [IDX_W-1:0]  in_idx;
  logic [WORD_W-1:0] in_val;
  logic [WIDX_W-1:0] widx;
  logic              err;

  assign in_idx = s_axis_tdata[IDX_W-1:0];
  assign in_val = s_axis_tdata[IDX_W +: WORD_W];
  assign acc    = s_axis_tvalid && s_axis_tready;

  assign is_sub   = (ctrl.op == OP_SUB_AB);
  assign is_shift = (ctrl.op == OP_RED_STEP) || (ctrl.op == OP_DBL);
  assign sh[0]    = ctrl.inbit;
  assign cc[0]    = is_sub;
  assign c2[0]    = !is_sub;
  // bit shifted out of the top word counts toward "at least m"
  assign pick = is_sub ? !cc[WORDS] : (cc[WORDS] || c2[WORDS] || (is_shift && sh[WORDS]));
  assign m_small = (m_vec[N-1:1] == '0);

  for (genvar i = 0; i < WORDS; i++) begin : g_cell
    logic sel;
    assign sel = (32'(in_idx) == i) && acc;
    mae_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .is_lsb   (i == 0),
      .pick     (pick),
      .ld_m     (sel && (s_axis_tuser == FN_LD_M)),
      .ld_a     (sel && (s_axis_tuser == FN_LD_A)),
      .ld_b     (sel && (s_axis_tuser == FN_LD_B)),
      .ld_val   (in_val),
      .shin     (sh[i]),
      .cin      (cc[i]),
      .c2in     (c2[i]),
      .shout    (sh[i+1]),
      .cout     (cc[i+1]),
      .c2out    (c2[i+1]),
      .m_word   (m_vec[i*WORD_W +: WORD_W]),
      .a_word   (a_vec[i*WORD_W +: WORD_W]),
      .b_word   (b_vec[i*WORD_W +: WORD_W]),
      .mp_word  (mp_vec[i*WORD_W +: WORD_W]),
      .res_word (res_w[i])
    );
  end

  mae_ctrl #(
    .WORDS (WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_func   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_widx  (widx),
    .out_last  (m_axis_tlast),
    .out_err   (err),
    .a_vec     (a_vec),
    .b_vec     (b_vec),
    .mp_vec    (mp_vec),
    .m_small   (m_small),
    .ctrl      (ctrl)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - WORD_W - IDX_W)'(0), IDX_W'(widx),
                         err ? WORD_W'(0) : res_w[widx]};
  assign m_axis_tuser = err;

endmodule

// ----- design/mae_checker.sv -----
// Port-level checks for the modular arithmetic engine, bound to the top level.
module mae_checker #(
  parameter int WORDS = mae_pkg::WORDS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mae_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                      m_axis_tuser,
  input logic                            m_axis_tlast
);
  import mae_pkg::*;

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[65:64] == 2'(WORDS - 1))
    else $error("last beat at wrong index");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[63:0] == 64'd0)
    else $error("error beat carries nonzero word");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while results pending");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside result burst");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled beat changed");

endmodule

bind modular_arithmetic_engine_top mae_checker #(.WORDS(WORDS)) u_mae_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
